// ----- rtl/esm_pkg.sv -----
// Shared types, constants and arithmetic helpers for the Euler scale/translate
// matrix block. No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps

package esm_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    localparam int QW    = 34;          // Q.30 working width for x, y, z
    localparam int RW    = 36;          // width used during angle reduction
    localparam int ANGW  = 16;
    localparam int SCW   = 16;
    localparam int POSW  = 32;
    localparam int OW    = 32;
    localparam int QUOW  = 25;          // quotient bits of 2^24 / |scale|
    localparam int REMW  = 17;
    localparam int DIV_STEPS = QUOW;
    localparam int PW    = OW + QW;     // factor times rotation entry
    localparam int SATW  = PW - 30;

    localparam int IN_DW  = 192;
    localparam int OUT_DW = 104;

    localparam logic MODE_MODEL  = 1'b0;
    localparam logic MODE_NORMAL = 1'b1;

    localparam logic [1:0] COL_LAST_NORMAL = 2'd2;
    localparam logic [1:0] COL_POS         = 2'd3;

    localparam logic signed [RW-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [RW-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [RW-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [QW-1:0] Q30_GAIN    = 34'sd652032874;

    localparam logic [OW-1:0] RECIP_SAT = 32'h7FFF_FFFF;

    localparam logic signed [QW-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    // Index 0 = x axis, 1 = y axis, 2 = z axis throughout.
    typedef struct packed {
        logic                  mode;
        logic [2:0]            flip;
        logic [2:0][QW-1:0]    x;
        logic [2:0][QW-1:0]    y;
        logic [2:0][QW-1:0]    z;
        logic [2:0][SCW-1:0]   sc;
        logic [2:0][REMW-1:0]  rem;
        logic [2:0][QUOW-1:0]  quo;
        logic [2:0][POSW-1:0]  pos;
    } stage_t;

    typedef struct packed {
        logic                      mode;
        logic [2:0][2:0][OW-1:0]   elem;   // [column][row]
        logic [2:0][POSW-1:0]      pos;
    } mat_t;

    // Q.30 product, floor shift
    function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        return p[QW+29:30];
    endfunction

    function automatic logic [OW-1:0] sat32(input logic signed [SATW-1:0] v);
        logic [OW-1:0] r;
        if (&v[SATW-1:OW-1] || ~|v[SATW-1:OW-1])
            r = v[OW-1:0];
        else if (v[SATW-1])
            r = 32'h8000_0000;
        else
            r = 32'h7FFF_FFFF;
        return r;
    endfunction

endpackage

// ----- rtl/esm_div_cell.sv -----
// One restoring-division cell: produces one quotient bit of 2^24 / |scale|
// for all three axes and passes the rest of the item on. Uses esm_pkg.
`timescale 1ns / 1ps

module esm_div_cell #(
    parameter int BIT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            valid_in,
    input  esm_pkg::stage_t d_in,
    output logic            valid_out,
    output esm_pkg::stage_t d_out
);
    import esm_pkg::*;

    stage_t               data_next;
    stage_t               data_reg;
    logic                 valid_reg;
    logic [2:0][REMW-1:0] mag;
    logic [2:0][REMW-1:0] trial;

    always_comb
    begin
        data_next = d_in;
        for (int a = 0; a < 3; a++)
        begin
            mag[a]   = d_in.sc[a][SCW-1] ? (~{1'b1, d_in.sc[a]} + 17'd1)
                                         : {1'b0, d_in.sc[a]};
            trial[a] = {d_in.rem[a][REMW-2:0], (BIT == QUOW - 1)};
            if (trial[a] >= mag[a])
            begin
                data_next.rem[a] = trial[a] - mag[a];
                data_next.quo[a] = {d_in.quo[a][QUOW-2:0], 1'b1};
            end
            else
            begin
                data_next.rem[a] = trial[a];
                data_next.quo[a] = {d_in.quo[a][QUOW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign d_out     = data_reg;

endmodule

// ----- rtl/esm_cordic_cell.sv -----
// One CORDIC rotation cell: a single micro-rotation for all three angles.
// Uses esm_pkg for the arctangent table and the item record.
`timescale 1ns / 1ps

module esm_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            valid_in,
    input  esm_pkg::stage_t d_in,
    output logic            valid_out,
    output esm_pkg::stage_t d_out
);
    import esm_pkg::*;

    stage_t                 data_next;
    stage_t                 data_reg;
    logic                   valid_reg;
    logic signed [QW-1:0]   xs [3];
    logic signed [QW-1:0]   ys [3];
    logic signed [QW-1:0]   zs [3];

    always_comb
    begin
        data_next = d_in;
        for (int a = 0; a < 3; a++)
        begin
            xs[a] = d_in.x[a];
            ys[a] = d_in.y[a];
            zs[a] = d_in.z[a];
            if (!zs[a][QW-1])
            begin
                data_next.x[a] = xs[a] - (ys[a] >>> STEP);
                data_next.y[a] = ys[a] + (xs[a] >>> STEP);
                data_next.z[a] = zs[a] - ATAN_Q30[STEP];
            end
            else
            begin
                data_next.x[a] = xs[a] + (ys[a] >>> STEP);
                data_next.y[a] = ys[a] - (xs[a] >>> STEP);
                data_next.z[a] = zs[a] + ATAN_Q30[STEP];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign d_out     = data_reg;

endmodule

// ----- rtl/esm_matrix.sv -----
// Four-stage rotation matrix and scaling pipeline: pair products, triple
// products, sums, then per-column scale with saturation. Uses esm_pkg.
`timescale 1ns / 1ps

module esm_matrix (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            valid_in,
    input  esm_pkg::stage_t d_in,
    output logic            valid_out,
    output esm_pkg::mat_t   m_out
);
    import esm_pkg::*;

    // c1,s1 from y axis, c2,s2 from x axis, c3,s3 from z axis
    logic signed [QW-1:0]  c [3];
    logic signed [QW-1:0]  s [3];
    logic signed [SCW-1:0] scs [3];
    logic [2:0][OW-1:0]    fac;
    logic [OW-1:0]         recip;

    // stage 1
    logic                  v1_reg;
    logic signed [QW-1:0]  c1c3_reg, s1s2_reg, c2s3_reg, c1s2_reg, c3s1_reg;
    logic signed [QW-1:0]  c1s3_reg, c2c3_reg, s1s3_reg, c2s1_reg, c1c2_reg;
    logic signed [QW-1:0]  s2_reg, s3_reg;
    logic [2:0][OW-1:0]    fac1_reg;
    logic [2:0][POSW-1:0]  pos1_reg;
    logic                  mode1_reg;

    // stage 2
    logic                  v2_reg;
    logic signed [QW-1:0]  t0_reg, t1_reg, t2_reg, t3_reg;
    logic signed [QW-1:0]  c1c3b_reg, c2s3b_reg, c3s1b_reg, c1s3b_reg;
    logic signed [QW-1:0]  c2c3b_reg, s1s3b_reg, c2s1b_reg, c1c2b_reg, s2b_reg;
    logic [2:0][OW-1:0]    fac2_reg;
    logic [2:0][POSW-1:0]  pos2_reg;
    logic                  mode2_reg;

    // stage 3
    logic                  v3_reg;
    logic [2:0][2:0][QW-1:0] rot3_reg;
    logic [2:0][OW-1:0]    fac3_reg;
    logic [2:0][POSW-1:0]  pos3_reg;
    logic                  mode3_reg;

    // stage 4
    logic                  v4_reg;
    mat_t                  m_reg;
    mat_t                  m_next;
    logic signed [PW-1:0]  prod [3][3];

    always_comb
    begin
        recip = '0;
        for (int a = 0; a < 3; a++)
        begin
            c[a]   = d_in.flip[a] ? -$signed(d_in.x[a]) : $signed(d_in.x[a]);
            s[a]   = d_in.flip[a] ? -$signed(d_in.y[a]) : $signed(d_in.y[a]);
            scs[a] = d_in.sc[a];
            if (scs[a] == '0)
                recip = RECIP_SAT;
            else if (scs[a][SCW-1])
                recip = ~{{(OW-QUOW){1'b0}}, d_in.quo[a]} + 32'd1;
            else
                recip = {{(OW-QUOW){1'b0}}, d_in.quo[a]};
            if (d_in.mode == MODE_NORMAL)
                fac[a] = recip;
            else
                fac[a] = {{(OW-SCW-8){scs[a][SCW-1]}}, scs[a], 8'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1c3_reg  <= mulq(c[1], c[2]);
            s1s2_reg  <= mulq(s[1], s[0]);
            c2s3_reg  <= mulq(c[0], s[2]);
            c1s2_reg  <= mulq(c[1], s[0]);
            c3s1_reg  <= mulq(c[2], s[1]);
            c1s3_reg  <= mulq(c[1], s[2]);
            c2c3_reg  <= mulq(c[0], c[2]);
            s1s3_reg  <= mulq(s[1], s[2]);
            c2s1_reg  <= mulq(c[0], s[1]);
            c1c2_reg  <= mulq(c[1], c[0]);
            s2_reg    <= s[0];
            s3_reg    <= s[2];
            fac1_reg  <= fac;
            pos1_reg  <= d_in.pos;
            mode1_reg <= d_in.mode;

            t0_reg    <= mulq(s1s2_reg, s3_reg);
            t1_reg    <= mulq(c1s2_reg, s3_reg);
            t2_reg    <= mulq(c3s1_reg, s2_reg);
            t3_reg    <= mulq(c1c3_reg, s2_reg);
            c1c3b_reg <= c1c3_reg;
            c2s3b_reg <= c2s3_reg;
            c3s1b_reg <= c3s1_reg;
            c1s3b_reg <= c1s3_reg;
            c2c3b_reg <= c2c3_reg;
            s1s3b_reg <= s1s3_reg;
            c2s1b_reg <= c2s1_reg;
            c1c2b_reg <= c1c2_reg;
            s2b_reg   <= s2_reg;
            fac2_reg  <= fac1_reg;
            pos2_reg  <= pos1_reg;
            mode2_reg <= mode1_reg;

            rot3_reg[0][0] <= c1c3b_reg + t0_reg;
            rot3_reg[0][1] <= c2s3b_reg;
            rot3_reg[0][2] <= t1_reg - c3s1b_reg;
            rot3_reg[1][0] <= t2_reg - c1s3b_reg;
            rot3_reg[1][1] <= c2c3b_reg;
            rot3_reg[1][2] <= t3_reg + s1s3b_reg;
            rot3_reg[2][0] <= c2s1b_reg;
            rot3_reg[2][1] <= -s2b_reg;
            rot3_reg[2][2] <= c1c2b_reg;
            fac3_reg  <= fac2_reg;
            pos3_reg  <= pos2_reg;
            mode3_reg <= mode2_reg;

            m_reg     <= m_next;
        end
    end

    always_comb
    begin
        m_next.mode = mode3_reg;
        m_next.pos  = pos3_reg;
        for (int k = 0; k < 3; k++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod[k][r] = $signed(fac3_reg[k]) * $signed(rot3_reg[k][r]);
                m_next.elem[k][r] = sat32(prod[k][r][PW-1:30]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign valid_out = v4_reg;
    assign m_out     = m_reg;

endmodule

// ----- rtl/euler_scale_translate_matrix.sv -----
// Top level of the Euler Y-X-Z model/normal matrix block: input stage with
// angle reduction, division and CORDIC cell chains, matrix pipeline, column
// serializer. Depends on esm_pkg, esm_div_cell, esm_cordic_cell, esm_matrix.
//
// Usage:
//   The s_axis channel takes one transfer per matrix: three Q4.12 angles,
//   three Q8.8 scales and a Q16.16 position, with the mode on tuser.
//   The m_axis channel returns one transfer per column: four columns for a
//   model matrix (the last one is the position), three for a normal matrix.
//   tlast marks the final column.
//   Path: an input transfer reaches the first output column through one
//   reduction stage, 25 division cells, CORDIC_STEPS rotation cells, four
//   matrix stages and the serializer register.
//   Throughput: one input every cycle through the cell chain while the
//   chain is not held; the single output port sends one column per
//   transfer: four per model matrix, three per normal matrix.
//   Reset clears every valid flag; the block then accepts at once.
//   When m_axis stalls, the finished matrix waits in the serializer and the
//   whole chain holds once its last stage is full; s_axis_tready drops then.

`timescale 1ns / 1ps

module euler_scale_translate_matrix #(
    parameter int CORDIC_STEPS = esm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z (16 b each),
    // pos_x, pos_y, pos_z (32 b each), from bit 0 up
    input  logic [esm_pkg::IN_DW-1:0]   s_axis_tdata,
    // mode
    input  logic                        s_axis_tuser,

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // column (2 b), elem_0, elem_1, elem_2 (32 b each), 6 zero bits
    output logic [esm_pkg::OUT_DW-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast
);
    import esm_pkg::*;

    localparam int NCELLS = DIV_STEPS + CORDIC_STEPS;

    logic                   adv;
    logic                   in_fire;
    stage_t                 in_next;
    stage_t                 in_reg;
    logic                   in_valid_reg;
    logic signed [RW-1:0]   z0 [3];
    logic signed [RW-1:0]   zr [3];

    stage_t                 link [NCELLS+1];
    logic                   lvalid [NCELLS+1];

    logic                   mat_valid;
    mat_t                   mat;

    logic                   ser_valid_reg;
    mat_t                   ser_mat_reg;
    logic [1:0]             col_reg;
    logic                   last_beat;
    logic [2:0][OW-1:0]     sel;

    // Advance the whole chain unless a finished matrix is stuck behind a
    // full serializer.
    assign last_beat = (ser_mat_reg.mode == MODE_NORMAL) ? (col_reg == COL_LAST_NORMAL)
                                                         : (col_reg == COL_POS);
    assign adv = !mat_valid || !ser_valid_reg || (m_axis_tready && last_beat);
    assign s_axis_tready = adv;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Input stage: widen angles to Q.30, fold into [-pi/2, pi/2], seed CORDIC
    always_comb
    begin
        in_next      = '0;
        in_next.mode = s_axis_tuser;
        for (int a = 0; a < 3; a++)
        begin
            z0[a] = {{(RW-ANGW-18){s_axis_tdata[a*ANGW+ANGW-1]}},
                     s_axis_tdata[a*ANGW +: ANGW], 18'b0};
            if (z0[a] > Q30_PI)
                zr[a] = z0[a] - Q30_TWO_PI;
            else if (z0[a] < -Q30_PI)
                zr[a] = z0[a] + Q30_TWO_PI;
            else
                zr[a] = z0[a];
            in_next.flip[a] = 1'b0;
            if (zr[a] > Q30_HALF_PI)
            begin
                zr[a] = zr[a] - Q30_PI;
                in_next.flip[a] = 1'b1;
            end
            else if (zr[a] < -Q30_HALF_PI)
            begin
                zr[a] = zr[a] + Q30_PI;
                in_next.flip[a] = 1'b1;
            end
            in_next.z[a]   = zr[a][QW-1:0];
            in_next.x[a]   = Q30_GAIN;
            in_next.y[a]   = '0;
            in_next.sc[a]  = s_axis_tdata[3*ANGW + a*SCW +: SCW];
            in_next.rem[a] = '0;
            in_next.quo[a] = '0;
            in_next.pos[a] = s_axis_tdata[3*ANGW + 3*SCW + a*POSW +: POSW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (adv)
            in_valid_reg <= in_fire;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            in_reg <= in_next;
    end

    assign link[0]   = in_reg;
    assign lvalid[0] = in_valid_reg;

    // Division cells: one quotient bit each, most significant first
    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++)
        begin : g_div
            esm_div_cell #(
                .BIT (QUOW - 1 - g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .valid_in  (lvalid[g]),
                .d_in      (link[g]),
                .valid_out (lvalid[g+1]),
                .d_out     (link[g+1])
            );
        end

        // CORDIC cells: one micro-rotation each
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_cordic
            esm_cordic_cell #(
                .STEP (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .valid_in  (lvalid[DIV_STEPS+g]),
                .d_in      (link[DIV_STEPS+g]),
                .valid_out (lvalid[DIV_STEPS+g+1]),
                .d_out     (link[DIV_STEPS+g+1])
            );
        end
    endgenerate

    esm_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (lvalid[NCELLS]),
        .d_in      (link[NCELLS]),
        .valid_out (mat_valid),
        .m_out     (mat)
    );

    // Serializer: load a finished matrix, then step through its columns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            col_reg       <= '0;
        end
        else if (adv && mat_valid)
        begin
            ser_valid_reg <= 1'b1;
            col_reg       <= '0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (last_beat)
                ser_valid_reg <= 1'b0;
            else
                col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && mat_valid)
            ser_mat_reg <= mat;
    end

    // Pick the column: rotation columns from the matrix, last one is position
    always_comb
    begin
        sel = ser_mat_reg.pos;
        for (int k = 0; k < 3; k++)
        begin
            if (col_reg == k[1:0])
                sel = ser_mat_reg.elem[k];
        end
    end

    assign m_axis_tvalid = ser_valid_reg;
    assign m_axis_tdata  = {6'b0, sel[2], sel[1], sel[0], col_reg};
    assign m_axis_tlast  = last_beat;

`ifndef SYNTHESIS
    a_normal_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (ser_valid_reg && ser_mat_reg.mode == MODE_NORMAL) |-> (col_reg != COL_POS))
        else $error("normal matrix reached the position column");

    a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
        |=> (m_axis_tvalid && col_reg == $past(col_reg) + 2'd1))
        else $error("column sequence broken inside a matrix");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && mat_valid))
        else $error("input stalled without a full output side");
`endif

endmodule
